>>> rtl/core/sgms_pkg.sv
// shared types and constants for the stereo gain mixer
package sgms_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_GAIN   = 2'd0;
   localparam logic [1:0] REG_FORMAT = 2'd1;
   localparam logic [1:0] REG_STEREO = 2'd2;

   // gain register
   localparam int unsigned GAIN_WIDTH = 17;
   localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = 17'h10000;

   // sample and sum widths
   localparam int unsigned SAMPLE_WIDTH = 16;
   localparam int unsigned VALUE_WIDTH  = 17;
   localparam int unsigned SUM_WIDTH    = 18;

   // clamp bounds and u8 offset
   localparam logic signed [SUM_WIDTH-1:0] S16_MIN   = -18'sd32768;
   localparam logic signed [SUM_WIDTH-1:0] S16_MAX   = 18'sd32767;
   localparam logic signed [SUM_WIDTH-1:0] U8_MIN    = 18'sd0;
   localparam logic signed [SUM_WIDTH-1:0] U8_MAX    = 18'sd255;
   localparam logic signed [SUM_WIDTH-1:0] U8_OFFSET = 18'sd128;

   // clamp tally
   localparam logic [15:0] TALLY_MAX = 16'hFFFF;

   // sample format codes
   localparam logic FMT_U8  = 1'b0;
   localparam logic FMT_S16 = 1'b1;

   // per-lane pipeline control
   typedef struct packed {
      logic load1;   // stage 1 takes a new word
      logic load2;   // stage 2 takes stage 1
      logic s16;     // signed 16-bit format
      logic active;  // lane mixes; otherwise passes the accumulator through
   } lane_ctrl_type;

endpackage

>>> rtl/core/stereo_gain_mix_saturate.sv
// top level of the stereo gain mixer with saturation
//
// Mixes one stereo frame per clock unless rsp backpressure stalls it: each lane
// multiplies the source sample by the Q16 gain (values above unity act as unity),
// adds the accumulator sample and clamps to signed 16-bit or unsigned 8-bit offset
// binary range. A new word is accepted every cycle while the pipeline has room; a
// result passes through the multiply register, the add-and-clamp register and the
// tally register in the merge stage. Each stage holds its word under rsp
// backpressure and fills bubbles independently. Configuration is to be written
// only while no words are in flight; the mono setting passes acc_right through.
module stereo_gain_mix_saturate (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // src_left, src_right, acc_left, acc_right
   input  logic [0:0]  req_tuser,   // first_frame
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_left, out_right, saturation_count
   output logic [1:0]  rsp_tuser,   // sat_left, sat_right
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import sgms_pkg::*;

   logic [GAIN_WIDTH-1:0] gain_ff, gain_eff;
   logic format_ff, stereo_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3;
   logic load1, load2, load3;
   logic first1_ff, first2_ff;
   lane_ctrl_type ctrl_left, ctrl_right;
   logic [SAMPLE_WIDTH-1:0] left_mix, right_mix;
   logic left_sat, right_sat;
   logic [SAMPLE_WIDTH-1:0] out_left, out_right;
   logic sat_left, sat_right;
   logic [15:0] saturation_count;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_UNITY;
         format_ff <= FMT_S16;
         stereo_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_GAIN:   gain_ff   <= csr_wdata;
            REG_FORMAT: format_ff <= csr_wdata[0];
            REG_STEREO: stereo_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign gain_eff = (gain_ff > GAIN_UNITY) ? GAIN_UNITY : gain_ff;

   // stage handshake: each stage moves when the next one has room
   always_comb begin
      ready3     = !v3_ff || rsp_tready;
      ready2     = !v2_ff || ready3;
      ready1     = !v1_ff || ready2;
      req_tready = ready1;
      load1      = req_tvalid && ready1;
      load2      = v1_ff && ready2;
      load3      = v2_ff && ready3;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_tvalid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   // first_frame travels alongside the lanes
   always_ff @(posedge clock) begin
      if (load1) first1_ff <= req_tuser[0];
      if (load2) first2_ff <= first1_ff;
   end

   // lane control
   always_comb begin
      ctrl_left.load1   = load1;
      ctrl_left.load2   = load2;
      ctrl_left.s16     = format_ff;
      ctrl_left.active  = 1'b1;
      ctrl_right        = ctrl_left;
      ctrl_right.active = stereo_ff;
   end

   sgms_lane u_lane_left (
      .clock      (clock),
      .ctrl       (ctrl_left),
      .gain       (gain_eff),
      .src        (req_tdata[15:0]),
      .acc        (req_tdata[47:32]),
      .out_sample (left_mix),
      .sat        (left_sat)
   );

   sgms_lane u_lane_right (
      .clock      (clock),
      .ctrl       (ctrl_right),
      .gain       (gain_eff),
      .src        (req_tdata[31:16]),
      .acc        (req_tdata[63:48]),
      .out_sample (right_mix),
      .sat        (right_sat)
   );

   sgms_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .load             (load3),
      .first_frame      (first2_ff),
      .left_sample      (left_mix),
      .right_sample     (right_mix),
      .left_sat         (left_sat),
      .right_sat        (right_sat),
      .out_left         (out_left),
      .out_right        (out_right),
      .sat_left         (sat_left),
      .sat_right        (sat_right),
      .saturation_count (saturation_count)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {saturation_count, out_right, out_left};
   assign rsp_tuser  = {sat_right, sat_left};

   // an empty pipeline always takes a word
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff && !v2_ff && !v3_ff |-> req_tready)
      else $error("empty pipeline refused a word");

endmodule

>>> rtl/core/sgms_lane.sv
// one channel: gain multiply, then accumulate and clamp
module sgms_lane (
   input  logic                               clock,
   input  sgms_pkg::lane_ctrl_type            ctrl,
   input  logic [sgms_pkg::GAIN_WIDTH-1:0]    gain,
   input  logic [sgms_pkg::SAMPLE_WIDTH-1:0]  src,
   input  logic [sgms_pkg::SAMPLE_WIDTH-1:0]  acc,
   output logic [sgms_pkg::SAMPLE_WIDTH-1:0]  out_sample,
   output logic                               sat
);
   import sgms_pkg::*;

   logic signed [VALUE_WIDTH-1:0]   src_val;
   logic signed [VALUE_WIDTH-1:0]   acc_val;
   logic signed [GAIN_WIDTH:0]      gain_s;
   logic signed [VALUE_WIDTH+GAIN_WIDTH:0] product;
   logic signed [VALUE_WIDTH-1:0]   scaled_in, scaled_ff;
   logic signed [VALUE_WIDTH-1:0]   acc_val_ff;
   logic [SAMPLE_WIDTH-1:0]         acc_raw_ff;
   logic signed [SUM_WIDTH-1:0]     sum;
   logic signed [SUM_WIDTH-1:0]     lo_bound, hi_bound;
   logic [SAMPLE_WIDTH-1:0]         out_in, out_ff;
   logic                            sat_in, sat_ff;

   // decode samples by format and scale; product >>> 16 is a floor
   always_comb begin
      if (ctrl.s16 == FMT_S16) begin
         src_val = signed'({src[SAMPLE_WIDTH-1], src});
         acc_val = signed'({acc[SAMPLE_WIDTH-1], acc});
      end else begin
         src_val = signed'({9'd0, src[7:0]});
         acc_val = signed'({9'd0, acc[7:0]});
      end
      gain_s    = signed'({1'b0, gain});
      product   = src_val * gain_s;
      scaled_in = product[VALUE_WIDTH+15:16];
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (ctrl.load1) begin
         scaled_ff  <= scaled_in;
         acc_val_ff <= acc_val;
         acc_raw_ff <= acc;
      end
   end

   // accumulate and clamp to the format range; an inactive lane passes acc through
   always_comb begin
      if (ctrl.s16 == FMT_S16) begin
         sum      = SUM_WIDTH'(scaled_ff) + SUM_WIDTH'(acc_val_ff);
         lo_bound = S16_MIN;
         hi_bound = S16_MAX;
      end else begin
         sum      = SUM_WIDTH'(scaled_ff) + SUM_WIDTH'(acc_val_ff) - U8_OFFSET;
         lo_bound = U8_MIN;
         hi_bound = U8_MAX;
      end
      if (!ctrl.active) begin
         out_in = acc_raw_ff;
         sat_in = 1'b0;
      end else if (sum < lo_bound) begin
         out_in = lo_bound[SAMPLE_WIDTH-1:0];
         sat_in = 1'b1;
      end else if (sum > hi_bound) begin
         out_in = hi_bound[SAMPLE_WIDTH-1:0];
         sat_in = 1'b1;
      end else begin
         out_in = sum[SAMPLE_WIDTH-1:0];
         sat_in = 1'b0;
      end
   end

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (ctrl.load2) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign out_sample = out_ff;
   assign sat        = sat_ff;

endmodule

>>> rtl/core/sgms_merge.sv
// merge stage: combines lane flags into the clamp tally and holds the result word
module sgms_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic                               first_frame,
   input  logic [sgms_pkg::SAMPLE_WIDTH-1:0]  left_sample,
   input  logic [sgms_pkg::SAMPLE_WIDTH-1:0]  right_sample,
   input  logic                               left_sat,
   input  logic                               right_sat,
   output logic [sgms_pkg::SAMPLE_WIDTH-1:0]  out_left,
   output logic [sgms_pkg::SAMPLE_WIDTH-1:0]  out_right,
   output logic                               sat_left,
   output logic                               sat_right,
   output logic [15:0]                        saturation_count
);
   import sgms_pkg::*;

   logic [15:0] tally_in, tally_ff;
   logic [15:0] base;
   logic [16:0] tally_sum;
   logic [SAMPLE_WIDTH-1:0] left_ff, right_ff;
   logic sat_left_ff, sat_right_ff;

   // first frame of a block restarts the count; saturate at the top
   always_comb begin
      base      = first_frame ? 16'd0 : tally_ff;
      tally_sum = {1'b0, base} + 17'(left_sat) + 17'(right_sat);
      tally_in  = tally_sum[16] ? TALLY_MAX : tally_sum[15:0];
   end

   // tally register
   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
      end else if (load) begin
         tally_ff <= tally_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (load) begin
         left_ff      <= left_sample;
         right_ff     <= right_sample;
         sat_left_ff  <= left_sat;
         sat_right_ff <= right_sat;
      end
   end

   assign out_left         = left_ff;
   assign out_right        = right_ff;
   assign sat_left         = sat_left_ff;
   assign sat_right        = sat_right_ff;
   assign saturation_count = tally_ff;

   // a clean first frame leaves the tally at zero
   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      load && first_frame && !left_sat && !right_sat |=> tally_ff == 16'd0)
      else $error("tally not cleared by a clean first frame");

   // inside a block the tally never goes down
   a_monotonic: assert property (@(posedge clock) disable iff (reset)
      load && !first_frame |=> tally_ff >= $past(tally_ff))
      else $error("tally decreased inside a block");

   // tally holds when nothing is loaded
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(tally_ff))
      else $error("tally changed without a word");

endmodule

>>> verif/tb_stereo_gain_mix_saturate.sv
// self-checking testbench for the stereo gain mixer with saturation
module tb_stereo_gain_mix_saturate;
   timeunit 1ns;
   timeprecision 1ps;
   import sgms_pkg::*;

   localparam logic MODE_MONO   = 1'b0;
   localparam logic MODE_STEREO = 1'b1;
   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 6;
   localparam int PHASES          = 8;
   localparam int PHASE_WORDS     = 110;
   localparam int TALLY_RUN_WORDS = 100;
   localparam int CYCLE_LIMIT     = 600000;

   // one input word and one result word
   typedef struct packed {
      logic [15:0] src_left;
      logic [15:0] src_right;
      logic [15:0] acc_left;
      logic [15:0] acc_right;
      logic        first_frame;
   } frame_type;

   typedef struct packed {
      logic [15:0] out_left;
      logic [15:0] out_right;
      logic        sat_left;
      logic        sat_right;
      logic [15:0] sat_count;
   } mix_type;

   // directed stimulus row: settings, word, and a hand-computed result where obvious
   typedef struct packed {
      logic [16:0] gain;
      logic        fmt;
      logic        stereo;
      frame_type   frame;
      logic        typed;
      mix_type     want;
   } dir_row_type;

   localparam dir_row_type DIRECTED [22] = '{
      // signed 16-bit at unity: zero, both rails, cancellation, tally restart
      '{GAIN_UNITY, FMT_S16, MODE_STEREO, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1},
        1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b0, 16'd0}},
      '{GAIN_UNITY, FMT_S16, MODE_STEREO, '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0},
        1'b1, '{16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 16'd2}},
      '{GAIN_UNITY, FMT_S16, MODE_STEREO, '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0},
        1'b1, '{16'h8000, 16'h8000, 1'b1, 1'b1, 16'd4}},
      '{GAIN_UNITY, FMT_S16, MODE_STEREO, '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0},
        1'b1, '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'd4}},
      '{GAIN_UNITY, FMT_S16, MODE_STEREO, '{16'h7FFF, 16'h0000, 16'h0001, 16'h0000, 1'b1},
        1'b1, '{16'h7FFF, 16'h0000, 1'b1, 1'b0, 16'd1}},
      // zero gain, gain above unity
      '{17'h00000, FMT_S16, MODE_STEREO, '{16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF, 1'b0},
        1'b1, '{16'h1234, 16'hFFFF, 1'b0, 1'b0, 16'd1}},
      '{17'h1FFFF, FMT_S16, MODE_STEREO, '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0},
        1'b1, '{16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'd3}},
      '{17'h10001, FMT_S16, MODE_STEREO, '{16'h4000, 16'hC000, 16'h0000, 16'h0000, 1'b0},
        1'b1, '{16'h4000, 16'hC000, 1'b0, 1'b0, 16'd3}},
      // fractional gains, floor rounding of negative products
      '{17'h00001, FMT_S16, MODE_STEREO, '{16'h8000, 16'h0001, 16'h0000, 16'h0000, 1'b0},
        1'b0, '0},
      '{17'h08000, FMT_S16, MODE_STEREO, '{16'hFFFF, 16'h0003, 16'h0005, 16'h0005, 1'b0},
        1'b0, '0},
      '{17'h0FFFF, FMT_S16, MODE_STEREO, '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b0},
        1'b0, '0},
      // unsigned 8-bit: both rails, offset, ignored high bytes
      '{GAIN_UNITY, FMT_U8, MODE_STEREO, '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1},
        1'b1, '{16'h00FF, 16'h00FF, 1'b1, 1'b1, 16'd2}},
      '{GAIN_UNITY, FMT_U8, MODE_STEREO, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        1'b1, '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'd4}},
      '{GAIN_UNITY, FMT_U8, MODE_STEREO, '{16'hAB80, 16'hFF80, 16'hCD80, 16'h0180, 1'b0},
        1'b1, '{16'h0080, 16'h0080, 1'b0, 1'b0, 16'd4}},
      '{17'h00000, FMT_U8, MODE_STEREO, '{16'hFFFF, 16'h00FF, 16'h0080, 16'h007F, 1'b0},
        1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1, 16'd5}},
      '{17'h08000, FMT_U8, MODE_STEREO, '{16'h00FF, 16'h0081, 16'h0040, 16'hFF7F, 1'b0},
        1'b0, '0},
      // mono: right accumulator passes through, right flag stays low
      '{GAIN_UNITY, FMT_S16, MODE_MONO, '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1},
        1'b1, '{16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'd1}},
      '{GAIN_UNITY, FMT_S16, MODE_MONO, '{16'h0001, 16'h8000, 16'h0002, 16'hBEEF, 1'b0},
        1'b1, '{16'h0003, 16'hBEEF, 1'b0, 1'b0, 16'd1}},
      '{GAIN_UNITY, FMT_U8, MODE_MONO, '{16'hFF10, 16'h00FF, 16'h0020, 16'hBEEF, 1'b0},
        1'b1, '{16'h0000, 16'hBEEF, 1'b1, 1'b0, 16'd2}},
      '{17'h1FFFF, FMT_U8, MODE_MONO, '{16'h00FF, 16'h1234, 16'h00FF, 16'h8000, 1'b0},
        1'b1, '{16'h00FF, 16'h8000, 1'b1, 1'b0, 16'd3}},
      // mixed gain, then a low-rail sum one below the limit
      '{17'h0C000, FMT_S16, MODE_STEREO, '{16'h9999, 16'h6666, 16'h1111, 16'hEEEE, 1'b1},
        1'b0, '0},
      '{GAIN_UNITY, FMT_S16, MODE_STEREO, '{16'hFFFF, 16'hFFFF, 16'h8000, 16'h8001, 1'b1},
        1'b1, '{16'h8000, 16'h8000, 1'b1, 1'b0, 16'd1}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // src_left, src_right, acc_left, acc_right
   logic [0:0]  req_tuser = '0;   // first_frame
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // out_left, out_right, saturation_count
   logic [1:0]  rsp_tuser;        // sat_left, sat_right
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_GAIN;
   logic [16:0] csr_wdata = '0;

   // mixer settings and clamp tally as the predictor sees them
   logic [16:0] cfg_gain = GAIN_UNITY;
   logic        cfg_format = FMT_S16;
   logic        cfg_stereo = MODE_STEREO;
   logic [15:0] clamp_tally = '0;

   mix_type expected_mix [$];
   int   mismatches = 0;
   int   cycle_count = 0;
   int   rx_stall = 0;
   bit   sender_calm = 1'b0;
   bit   rx_calm = 1'b0;

   stereo_gain_mix_saturate uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10ns clock = ~clock;

   // one lane: scale by the clamped gain (floor), add, clamp to the format range
   function automatic logic [15:0] mix_lane(input logic [15:0] src, input logic [15:0] acc,
                                            output logic clamped);
      int     g;
      int     sv;
      int     av;
      int     lo;
      int     hi;
      int     sum;
      longint prod;
      g = (cfg_gain > GAIN_UNITY) ? int'(GAIN_UNITY) : int'(cfg_gain);
      if (cfg_format == FMT_S16) begin
         sv = int'($signed(src));
         av = int'($signed(acc));
         lo = int'(S16_MIN);
         hi = int'(S16_MAX);
      end else begin
         sv = int'(src[7:0]);
         av = int'(acc[7:0]) - int'(U8_OFFSET);
         lo = int'(U8_MIN);
         hi = int'(U8_MAX);
      end
      prod = longint'(sv) * longint'(g);
      sum = av + int'(prod >>> 16);
      clamped = (sum < lo) || (sum > hi);
      if (sum < lo) sum = lo;
      if (sum > hi) sum = hi;
      return sum[15:0];
   endfunction

   // whole frame plus the block tally update
   function automatic mix_type predict_mix(input frame_type f);
      mix_type     m;
      logic [16:0] t;
      m.out_left = mix_lane(f.src_left, f.acc_left, m.sat_left);
      if (cfg_stereo == MODE_STEREO) begin
         m.out_right = mix_lane(f.src_right, f.acc_right, m.sat_right);
      end else begin
         m.out_right = f.acc_right;
         m.sat_right = 1'b0;
      end
      t = f.first_frame ? 17'd0 : {1'b0, clamp_tally};
      t = t + 17'(m.sat_left) + 17'(m.sat_right);
      if (t > {1'b0, TALLY_MAX}) t = {1'b0, TALLY_MAX};
      clamp_tally = t[15:0];
      m.sat_count = t[15:0];
      return m;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_length(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(10, 30);
   endfunction

   // random sample biased toward the rails and the byte edges
   function automatic logic [15:0] rand_sample();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return {r[15:8], 8'hFF};
         3: return {r[15:8], 8'h00};
         default: return r[15:0];
      endcase
   endfunction

   // sample near one rail so that a pair of them always clamps
   function automatic logic [15:0] loud_sample(input logic neg);
      logic [31:0] r;
      r = $urandom;
      return neg ? {4'h8, r[11:0]} : {4'h7, r[11:0]};
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   // offer one word, wait for the handshake, queue its expected result
   task automatic send_frame(input frame_type f, input logic typed, input mix_type want);
      int      gap;
      mix_type m;
      gap = idle_length(sender_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {f.acc_right, f.acc_left, f.src_right, f.src_left};
      req_tuser  <= f.first_frame;
      do @(posedge clock); while (!req_tready);
      m = predict_mix(f);
      expected_mix = {expected_mix, (typed ? want : m)};
   endtask

   // stop sending and wait until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_mix.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers, block must be idle
   task automatic apply_config(input logic [16:0] g, input logic fmt, input logic st);
      csr_we    <= 1'b1;
      csr_index <= REG_GAIN;
      csr_wdata <= g;
      @(posedge clock);
      csr_index <= REG_FORMAT;
      csr_wdata <= {16'd0, fmt};
      @(posedge clock);
      csr_index <= REG_STEREO;
      csr_wdata <= {16'd0, st};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_gain   = g;
      cfg_format = fmt;
      cfg_stereo = st;
   endtask

   // result side: compare each word, then decide on backpressure
   always @(posedge clock) begin
      mix_type got;
      mix_type want_mix;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_left  = rsp_tdata[15:0];
            got.out_right = rsp_tdata[31:16];
            got.sat_count = rsp_tdata[47:32];
            got.sat_left  = rsp_tuser[0];
            got.sat_right = rsp_tuser[1];
            if (expected_mix.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want_mix = expected_mix.pop_front();
               check_field("out_left", want_mix.out_left, got.out_left);
               check_field("out_right", want_mix.out_right, got.out_right);
               check_field("sat_left", 16'(want_mix.sat_left), 16'(got.sat_left));
               check_field("sat_right", 16'(want_mix.sat_right), 16'(got.sat_right));
               check_field("saturation_count", want_mix.sat_count, got.sat_count);
            end
         end
         if (rx_stall > 0) begin
            rsp_tready <= 1'b0;
            rx_stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 99) < 25) rx_stall = idle_length(1'b0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      frame_type   f;
      logic [16:0] g;
      logic        fmt;
      logic        st;
      logic        neg_l;
      logic        neg_r;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, new settings applied only with nothing in flight
      for (int i = 0; i < $size(DIRECTED); i++) begin
         if (DIRECTED[i].gain !== cfg_gain || DIRECTED[i].fmt !== cfg_format ||
             DIRECTED[i].stereo !== cfg_stereo) begin
            drain();
            apply_config(DIRECTED[i].gain, DIRECTED[i].fmt, DIRECTED[i].stereo);
         end
         send_frame(DIRECTED[i].frame, DIRECTED[i].typed, DIRECTED[i].want);
      end

      // random phases, the first four pinned to the extremes
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin g = GAIN_UNITY; fmt = FMT_S16; st = MODE_STEREO; end
            1: begin g = 17'h00000;  fmt = FMT_U8;  st = MODE_STEREO; end
            2: begin g = 17'h1FFFF;  fmt = FMT_S16; st = MODE_MONO;   end
            3: begin g = GAIN_UNITY; fmt = FMT_U8;  st = MODE_MONO;   end
            default: begin
               if ($urandom_range(0, 3) == 0) g = 17'($urandom_range(65537, 131071));
               else g = 17'($urandom_range(0, 65536));
               fmt = ($urandom_range(0, 1) == 1) ? FMT_S16 : FMT_U8;
               st  = ($urandom_range(0, 1) == 1) ? MODE_STEREO : MODE_MONO;
            end
         endcase
         drain();
         apply_config(g, fmt, st);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (k % 50 == 0) begin
               sender_calm = ($urandom_range(0, 3) == 0);
               rx_calm     = ($urandom_range(0, 3) == 0);
            end
            f.src_left    = rand_sample();
            f.src_right   = rand_sample();
            f.acc_left    = rand_sample();
            f.acc_right   = rand_sample();
            f.first_frame = ($urandom_range(0, 19) == 0);
            send_frame(f, 1'b0, '0);
         end
      end

      // block of clamping frames back to back, tally climbs by two per word
      drain();
      apply_config(GAIN_UNITY, FMT_S16, MODE_STEREO);
      sender_calm = 1'b1;
      rx_calm     = 1'b1;
      for (int k = 0; k < TALLY_RUN_WORDS; k++) begin
         neg_l = $urandom_range(0, 1);
         neg_r = $urandom_range(0, 1);
         f.src_left    = loud_sample(neg_l);
         f.acc_left    = loud_sample(neg_l);
         f.src_right   = loud_sample(neg_r);
         f.acc_right   = loud_sample(neg_r);
         f.first_frame = (k == 0);
         send_frame(f, 1'b0, '0);
      end
      sender_calm = 1'b0;
      rx_calm     = 1'b0;

      drain();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
